// ===== sv/pwng_pkg.sv =====
`timescale 1ns / 1ps

package pwng_pkg;

   // Fixed field widths.
   localparam int SAMPLE_W = 16;
   localparam int THR_W    = 15;

   // Defaults for the top-level parameter and the threshold register.
   localparam int               WINDOW_DEFAULT  = 32;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd500;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store;         // write the accepted sample, advance pointers
      logic peak_clear;    // start a new peak search
      logic cnt_clear;     // restart the scan/emit counter
      logic cnt_step;      // advance the scan/emit counter
      logic ptr_load;      // point the emit pointer at the oldest sample
      logic ptr_step;      // advance the emit pointer with wrap
      logic rd_sel_ptr;    // read address from emit pointer, else counter
      logic acc_issue;     // the read issued now feeds the peak search
      logic out_load;      // load the result register
      logic out_sel_hist;  // result from the ring, else the current sample
      logic out_last;      // last_of_run of the loaded result
   } pwng_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fill_hit;      // ring is full once the current sample is stored
      logic cnt_last;      // counter is at the last window position
      logic peak_above;    // window peak strictly exceeds the threshold
      logic out_free;      // result register can take a new result
   } pwng_stat_type;

   // Magnitude of a two's complement sample; -32768 maps to 32768.
   function automatic logic [SAMPLE_W-1:0] magnitude(input logic [SAMPLE_W-1:0] value);
      logic [SAMPLE_W-1:0] neg;
      begin
         neg = ~value + SAMPLE_W'(1);
         return value[SAMPLE_W-1] ? neg : value;
      end
   endfunction

endpackage

// ===== sv/pwng_if.sv =====
`timescale 1ns / 1ps

// Input sample channel.
interface pwng_req_if;
   logic                        valid;
   logic                        ready;
   logic signed [15:0]          sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// Result channel.
interface pwng_rsp_if;
   logic                        valid;
   logic                        ready;
   logic signed [15:0]          sample_out;
   logic                        last_of_run;

   modport source (output valid, output sample_out, output last_of_run, input ready);
   modport sink   (input valid, input sample_out, input last_of_run, output ready);
endinterface

// Threshold register write channel.
interface pwng_csr_if;
   logic                        valid;
   logic                        ready;
   logic [14:0]                 threshold;

   modport source (output valid, output threshold, input ready);
   modport sink   (input valid, input threshold, output ready);
endinterface

// ===== sv/pwng_datapath.sv =====
`timescale 1ns / 1ps

module pwng_datapath #(
   parameter int WINDOW = pwng_pkg::WINDOW_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pwng_pkg::pwng_cmd_type              cmd,
   output pwng_pkg::pwng_stat_type             stat,
   input  logic [pwng_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                                csr_valid,
   input  logic [pwng_pkg::THR_W-1:0]          csr_threshold,
   output logic                                csr_ready,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [pwng_pkg::SAMPLE_W-1:0]       rsp_sample_out,
   output logic                                rsp_last_of_run
);
   import pwng_pkg::*;

   localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
   localparam logic [FILL_W-1:0] FILL_NEAR = FILL_W'(WINDOW - 1);

   logic [SAMPLE_W-1:0] hist_mem [WINDOW];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]    rd_addr;

   logic [PTR_W-1:0]    wp_ff, wp_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [PTR_W-1:0]    cnt_ff, cnt_in;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] peak_ff, peak_in;
   logic [SAMPLE_W-1:0] rd_mag;
   logic                acc_vld_ff;
   logic [THR_W-1:0]    thr_ff;
   logic                out_vld_ff, out_vld_in;
   logic [SAMPLE_W-1:0] out_data_ff;
   logic                out_last_ff;

   // Sample ring: one write port, one registered read port.
   assign rd_addr = cmd.rd_sel_ptr ? ptr_ff : cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         hist_mem[wp_ff] <= req_sample;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

   // Write pointer and fill count.
   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      if (cmd.store) begin
         wp_in = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
         if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   // The current sample is held for a single-sample result.
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         sample_ff <= req_sample;
      end
   end

   // Scan/emit counter and the emit pointer that walks oldest first.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_step) begin
         cnt_in = cnt_ff + PTR_W'(1);
      end
      ptr_in = ptr_ff;
      if (cmd.ptr_load) begin
         ptr_in = wp_ff;
      end else if (cmd.ptr_step) begin
         ptr_in = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ptr_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         ptr_ff <= ptr_in;
      end
   end

   // Running peak; the read data arrives in the cycle after its issue.
   assign rd_mag = magnitude(rd_data_ff);

   always_comb begin
      peak_in = peak_ff;
      if (cmd.peak_clear) begin
         peak_in = '0;
      end else if (acc_vld_ff && (rd_mag > peak_ff)) begin
         peak_in = rd_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= 1'b0;
         peak_ff    <= '0;
      end else begin
         acc_vld_ff <= cmd.acc_issue;
         peak_ff    <= peak_in;
      end
   end

   // Threshold register; a write is always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_threshold;
      end
   end

   // Result register parts the datapath from the downstream stall.
   assign out_vld_in = cmd.out_load | (out_vld_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_data_ff <= cmd.out_sel_hist ? rd_data_ff : sample_ff;
         out_last_ff <= cmd.out_last;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_sample_out  = out_data_ff;
   assign rsp_last_of_run = out_last_ff;

   // Status back to the controller.
   assign stat.fill_hit   = (fill_ff == FILL_FULL) || (fill_ff == FILL_NEAR);
   assign stat.cnt_last   = (cnt_ff == PTR_LAST);
   assign stat.peak_above = (peak_ff > {1'b0, thr_ff});
   assign stat.out_free   = ~out_vld_ff | rsp_ready;

endmodule

// ===== sv/pwng_controller.sv =====
`timescale 1ns / 1ps

module pwng_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pwng_pkg::pwng_stat_type stat,
   output pwng_pkg::pwng_cmd_type  cmd
);
   import pwng_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_DRAIN    = 3'd2;
   localparam logic [2:0] S_DECIDE   = 3'd3;
   localparam logic [2:0] S_EMIT_RD  = 3'd4;
   localparam logic [2:0] S_EMIT_LD  = 3'd5;
   localparam logic [2:0] S_EMIT_ONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       gate_ff, gate_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      gate_in  = gate_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.store      = 1'b1;
               cmd.peak_clear = 1'b1;
               cmd.cnt_clear  = 1'b1;
               if (stat.fill_hit) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // One ring read per cycle into the peak search.
            cmd.acc_issue = 1'b1;
            cmd.cnt_step  = 1'b1;
            if (stat.cnt_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!stat.peak_above) begin
               state_in = S_IDLE;
            end else if (gate_ff) begin
               state_in = S_EMIT_ONE;
            end else begin
               gate_in       = 1'b1;
               cmd.ptr_load  = 1'b1;
               cmd.cnt_clear = 1'b1;
               state_in      = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            cmd.rd_sel_ptr = 1'b1;
            state_in       = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            // Hold the read address until the result register frees up.
            cmd.rd_sel_ptr = 1'b1;
            if (stat.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_sel_hist = 1'b1;
               cmd.out_last     = stat.cnt_last;
               cmd.ptr_step     = 1'b1;
               cmd.cnt_step     = 1'b1;
               state_in         = stat.cnt_last ? S_IDLE : S_EMIT_RD;
            end
         end
         S_EMIT_ONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gate_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         gate_ff  <= gate_in;
      end
   end

endmodule

// ===== sv/peak_window_noise_gate_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Payload                       Transfer when
// req_ch    in         sample (s16)                  valid && ready
// rsp_ch    out        sample_out (s16), last_of_run valid && ready
// csr_ch    in         threshold (u15)               valid && ready
//
// While the ring fills, a sample is stored and the block stays ready. Once
// it is full, the peak search reads the ring through its single read port,
// one entry per cycle, and no new sample is taken until the gate has decided
// and sent its results. An opening gate sends the window oldest first;
// an open gate sends a single result. A stalled result port holds the block.
// Synchronous active-high reset closes the gate and empties the ring.

module peak_window_noise_gate_core #(
   parameter int WINDOW = pwng_pkg::WINDOW_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   pwng_req_if.sink   req_ch,
   pwng_rsp_if.source rsp_ch,
   pwng_csr_if.sink   csr_ch
);
   import pwng_pkg::*;

   pwng_cmd_type  cmd;
   pwng_stat_type stat;

   pwng_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pwng_datapath #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_sample      (req_ch.sample),
      .csr_valid       (csr_ch.valid),
      .csr_threshold   (csr_ch.threshold),
      .csr_ready       (csr_ch.ready),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_sample_out  (rsp_ch.sample_out),
      .rsp_last_of_run (rsp_ch.last_of_run)
   );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import pwng_pkg::*;

   localparam int WINDOW       = WINDOW_DEFAULT;
   localparam int DRAIN_CYCLES = 3 * WINDOW + 16;
   localparam int PHASE_COUNT  = 9;
   localparam int PHASE_LEN    = 30;
   localparam int REPORT_CAP   = 40;

   // One result as it should come out of the gate.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } passed_sample_type;

   // Kinds of audio that a random phase sends.
   typedef enum int {
      QUIET_SPARSE,
      FULL_SCALE,
      NEAR_THRESHOLD,
      QUIET_THEN_LOUD
   } phase_style_type;

   logic clock;
   logic reset;

   pwng_req_if req_if ();
   pwng_rsp_if rsp_if ();
   pwng_csr_if csr_if ();

   peak_window_noise_gate_core #(
      .WINDOW(WINDOW)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_ch(csr_if)
   );

   // Gate model state, kept in step with every accepted transfer.
   logic [SAMPLE_W-1:0] ring_mem [WINDOW];
   int                  ring_wr_pos   = 0;
   int                  ring_fill     = 0;
   bit                  gate_is_open  = 1'b0;
   logic [THR_W-1:0]    gate_thr      = THRESHOLD_RESET;

   passed_sample_type pending_passes[$];
   int                err_count   = 0;
   bit                idling_on   = 1'b1;
   int                stall_left  = 0;

   always #5 clock = ~clock;

   initial clock = 1'b0;

   // The run cannot hang: a stuck handshake or a missing result ends here.
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (err_count < REPORT_CAP) begin
         $display("%0t ns: mismatch: %s", $time, msg);
      end
      err_count++;
   endtask

   // Magnitude with -32768 counted as 32768.
   function automatic int sample_magnitude(input logic [SAMPLE_W-1:0] value);
      if (value[SAMPLE_W-1]) begin
         return 65536 - int'(value);
      end
      return int'(value);
   endfunction

   // Store one sample and queue the results the gate should produce for it.
   function automatic void gate_predict(input logic [SAMPLE_W-1:0] value);
      int                peak;
      int                k;
      passed_sample_type res;
      ring_mem[ring_wr_pos] = value;
      ring_wr_pos = (ring_wr_pos + 1) % WINDOW;
      if (ring_fill < WINDOW) begin
         ring_fill++;
      end
      if (ring_fill < WINDOW) begin
         return;
      end
      peak = 0;
      for (k = 0; k < WINDOW; k++) begin
         if (sample_magnitude(ring_mem[k]) > peak) begin
            peak = sample_magnitude(ring_mem[k]);
         end
      end
      if (peak <= int'(gate_thr)) begin
         return;
      end
      // The opening sample releases the whole window, oldest first.
      if (!gate_is_open) begin
         gate_is_open = 1'b1;
         for (k = 0; k < WINDOW; k++) begin
            res.sample = ring_mem[(ring_wr_pos + k) % WINDOW];
            res.last   = (k == WINDOW - 1);
            pending_passes.insert(pending_passes.size(), res);
         end
         return;
      end
      res.sample = value;
      res.last   = 1'b1;
      pending_passes.insert(pending_passes.size(), res);
   endfunction

   // Send one sample, with an occasional idle burst ahead of it.
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= value;
      do @(posedge clock); while (!req_if.ready);
      gate_predict(value);
   endtask

   // Stop sending and let every queued result and any scan in flight finish.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_passes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      csr_if.valid     <= 1'b1;
      csr_if.threshold <= value;
      do @(posedge clock); while (!csr_if.ready);
      gate_thr = value;
      csr_if.valid <= 1'b0;
   endtask

   // Random sample shaped by the phase style and the current threshold.
   function automatic logic [SAMPLE_W-1:0] pick_sample(input phase_style_type style,
                                                        input int idx, input int thr_now);
      int mag;
      mag = 0;
      case (style)
         QUIET_SPARSE: begin
            if ($urandom_range(0, 7) != 0) begin
               return '0;
            end
            mag = $urandom_range(0, thr_now + 1);
         end
         FULL_SCALE: begin
            return SAMPLE_W'($urandom);
         end
         NEAR_THRESHOLD: begin
            mag = thr_now - 1 + $urandom_range(0, 2);
         end
         default: begin
            if (idx >= PHASE_LEN - 2) begin
               return SAMPLE_W'($urandom);
            end
            mag = $urandom_range(0, thr_now);
         end
      endcase
      if (mag < 0) begin
         mag = 0;
      end
      if (mag > 32768) begin
         mag = 32768;
      end
      return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
   endfunction

   // Fill the ring under the highest threshold: nothing may come out,
   // not even once the ring is full with a peak equal to the threshold.
   task automatic test_window_fill();
      logic [SAMPLE_W-1:0] edge_vals [9];
      logic [SAMPLE_W-1:0] value;
      int                  k;
      edge_vals = '{16'h7FFF, 16'h8001, 16'h0000, 16'hFFFF, 16'h0001,
                    16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
      write_threshold(15'h7FFF);
      for (k = 0; k < WINDOW; k++) begin
         if (k < 9) begin
            value = edge_vals[k];
         end else begin
            value = SAMPLE_W'($urandom);
            if (value == 16'h8000) begin
               value = 16'h8001;
            end
         end
         send_sample(value);
      end
      send_sample(16'h7FFF);
   endtask

   // The most negative sample has magnitude 32768 and opens the gate,
   // releasing the whole window; the next sample passes on its own.
   task automatic test_gate_opening();
      send_sample(16'h8000);
      send_sample(16'h0001);
      wait_drained();
   endtask

   // Phases with their own threshold and kind of audio. The first three
   // use zero, one and the highest threshold; the last runs without idling.
   task automatic test_random_phases();
      int              p;
      int              k;
      int              thr_now;
      phase_style_type style;
      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin
               thr_now = 0;
               style   = QUIET_SPARSE;
            end
            1: begin
               thr_now = 1;
               style   = NEAR_THRESHOLD;
            end
            2: begin
               thr_now = 32767;
               style   = FULL_SCALE;
            end
            default: begin
               thr_now = $urandom_range(1, 32767);
               style   = phase_style_type'(p % 4);
            end
         endcase
         if (p == PHASE_COUNT - 1) begin
            idling_on = 1'b0;
         end
         write_threshold(THR_W'(thr_now));
         for (k = 0; k < PHASE_LEN; k++) begin
            send_sample(pick_sample(style, k, thr_now));
         end
         wait_drained();
      end
   endtask

   // Result checking and receiver stalls share one clocked process.
   always @(posedge clock) begin
      passed_sample_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_passes.size() == 0) begin
            report_mismatch($sformatf("unexpected result sample_out=%0d last_of_run=%0b",
                                      rsp_if.sample_out, rsp_if.last_of_run));
         end else begin
            want = pending_passes[0];
            pending_passes.delete(0);
            if (rsp_if.sample_out !== want.sample) begin
               report_mismatch($sformatf("sample_out=%0d, want %0d",
                                         rsp_if.sample_out, $signed(want.sample)));
            end
            if (rsp_if.last_of_run !== want.last) begin
               report_mismatch($sformatf("last_of_run=%0b, want %0b",
                                         rsp_if.last_of_run, want.last));
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.sample    <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.threshold <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_window_fill();
      test_gate_opening();
      test_random_phases();
      wait_drained();

      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
